// ===== src/sha256_single_block_hash_core_assert.svh =====
// Assertion macros shared by the single-block hash core
`ifndef SHA256_SINGLE_BLOCK_HASH_CORE_ASSERT_SVH
`define SHA256_SINGLE_BLOCK_HASH_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define SBH_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high
`define SBH_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== src/sha256sb_pkg.sv =====
// Shared types, constants and round functions for the single-block hash core
package sha256sb_pkg;

  // Largest message that fits one padded block
  localparam int MsgDepth = 55;
  localparam logic [5:0] MSG_BYTES = 6'd55;

  // Command passed from the front end to the hash engine
  typedef struct packed {
    logic [7:0] data;
    logic       store;
    logic       finish;
    logic       err;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT,
    ST_ERROR
  } back_state_t;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

// ===== src/sha256sb_front.sv =====
// Input front end: takes byte transfers, tracks length and overflow, issues commands
module sha256sb_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          data_byte,
  input  logic                has_byte,
  input  logic                end_of_message,
  input  logic                q_full,
  output logic                q_push,
  output sha256sb_pkg::cmd_t  q_cmd
);
  import sha256sb_pkg::*;

  logic [5:0] count;
  logic [5:0] count_next;
  logic       overflow;
  logic       overflow_next;
  logic       accept;
  logic       fits;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign fits     = count < MSG_BYTES;

  // Classify the item; a byte past the limit only marks the message as too long
  always_comb begin
    q_cmd.data   = data_byte;
    q_cmd.store  = has_byte && fits;
    q_cmd.finish = end_of_message;
    q_cmd.err    = overflow || (has_byte && !fits);
    q_push       = accept && (q_cmd.store || end_of_message);
  end

  // Length and overflow tracking, cleared by every end item
  always_comb begin
    count_next    = count;
    overflow_next = overflow;
    if (accept) begin
      if (end_of_message) begin
        count_next    = '0;
        overflow_next = 1'b0;
      end else if (has_byte) begin
        if (fits) begin
          count_next = count + 6'd1;
        end else begin
          overflow_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      count    <= count_next;
      overflow <= overflow_next;
    end
  end

endmodule

// ===== src/sha256sb_fifo.sv =====
// Short command queue between the front end and the hash engine
module sha256sb_fifo #(
  parameter int Depth = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sha256sb_pkg::cmd_t  push_cmd,
  output logic                full,
  input  logic                pop,
  output sha256sb_pkg::cmd_t  head_cmd,
  output logic                empty
);
  import sha256sb_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LAST_PTR = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FULL_CNT = CntW'(Depth);

  cmd_t            entries [Depth];
  logic [PtrW-1:0] head;
  logic [PtrW-1:0] tail;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full     = count == FULL_CNT;
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = entries[head];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[tail] <= push_cmd;
    end
  end

  // Pointers wrap at the depth, which need not be a power of two
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == LAST_PTR) ? '0 : tail + PtrW'(1);
      end
      if (do_pop) begin
        head <= (head == LAST_PTR) ? '0 : head + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// ===== src/sha256sb_back.sv =====
// Hash engine: byte store, block assembly with padding, 64 rounds, digest output
module sha256sb_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  sha256sb_pkg::cmd_t  q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         digest_word,
  output logic [2:0]          word_index,
  output logic                too_long,
  output logic                last_word
);
  import sha256sb_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic [7:0]   msg_mem [MsgDepth];
  logic [5:0]   count;
  logic [6:0]   ld_cnt;
  logic [5:0]   pos;
  logic         shift_en;
  logic [7:0]   rd_data;
  logic [7:0]   blk_byte;
  logic [511:0] win;
  logic [31:0]  wa, wb, wc, wd, we, wf, wg, wh;
  logic [31:0]  hv [8];
  logic [5:0]   rnd;
  logic [2:0]   idx;
  logic         out_xfer;
  logic         load_done;
  logic         do_store;
  logic [31:0]  t1;
  logic [31:0]  t2;
  logic [31:0]  w_new;

  assign out_xfer  = out_valid && !out_stall;
  assign load_done = shift_en && (pos == 6'd63);
  assign do_store  = q_pop && q_cmd.store && (count < MSG_BYTES);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs
  always_comb begin
    state_next  = state;
    q_pop       = 1'b0;
    out_valid   = 1'b0;
    digest_word = '0;
    word_index  = '0;
    too_long    = 1'b0;
    last_word   = 1'b0;
    case (state)
      ST_IDLE: begin
        q_pop = !q_empty;
        if (!q_empty && q_cmd.finish) begin
          state_next = q_cmd.err ? ST_ERROR : ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (load_done) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd == 6'd63) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid   = 1'b1;
        digest_word = hv[idx];
        word_index  = idx;
        last_word   = idx == 3'd7;
        if (!out_stall && idx == 3'd7) begin
          state_next = ST_IDLE;
        end
      end
      ST_ERROR: begin
        out_valid = 1'b1;
        too_long  = 1'b1;
        last_word = 1'b1;
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Message byte store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (do_store) begin
      msg_mem[count] <= q_cmd.data;
    end
    if (state == ST_LOAD && ld_cnt < {1'b0, MSG_BYTES}) begin
      rd_data <= msg_mem[ld_cnt[5:0]];
    end
  end

  // Sequencing counters
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      ld_cnt   <= '0;
      shift_en <= 1'b0;
      rnd      <= '0;
      idx      <= '0;
    end else begin
      shift_en <= 1'b0;
      case (state)
        ST_IDLE: begin
          ld_cnt <= '0;
          rnd    <= '0;
          idx    <= '0;
          if (do_store) begin
            count <= count + 6'd1;
          end
        end
        ST_LOAD: begin
          if (ld_cnt != 7'd64) begin
            ld_cnt   <= ld_cnt + 7'd1;
            shift_en <= 1'b1;
          end
        end
        ST_ROUND: begin
          rnd <= rnd + 6'd1;
        end
        ST_EMIT: begin
          if (out_xfer) begin
            idx <= idx + 3'd1;
            if (idx == 3'd7) begin
              count <= '0;
            end
          end
        end
        ST_ERROR: begin
          if (out_xfer) begin
            count <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Padded block byte: message, 0x80 marker, zeros, 16-bit bit length at the end
  always_comb begin
    if (pos < count) begin
      blk_byte = rd_data;
    end else if (pos == count) begin
      blk_byte = 8'h80;
    end else if (pos == 6'd62) begin
      blk_byte = {7'd0, count[5]};
    end else if (pos == 6'd63) begin
      blk_byte = {count[4:0], 3'b000};
    end else begin
      blk_byte = 8'h00;
    end
  end

  // Round logic; the schedule window supplies w[i] at its top word
  always_comb begin
    t1 = wh + big_sigma1(we) + ((we & wf) ^ (~we & wg)) + ROUND_K[rnd] + win[511:480];
    t2 = big_sigma0(wa) + ((wa & (wb ^ wc)) ^ (wb & wc));
    w_new = win[511:480] + small_sigma0(win[479:448]) + win[223:192]
            + small_sigma1(win[63:32]);
  end

  // Block window, working variables and digest words
  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        pos <= ld_cnt[5:0];
        if (shift_en) begin
          win <= {win[503:0], blk_byte};
        end
        if (load_done) begin
          wa <= INIT_H[0];
          wb <= INIT_H[1];
          wc <= INIT_H[2];
          wd <= INIT_H[3];
          we <= INIT_H[4];
          wf <= INIT_H[5];
          wg <= INIT_H[6];
          wh <= INIT_H[7];
        end
      end
      ST_ROUND: begin
        win <= {win[479:0], w_new};
        wh  <= wg;
        wg  <= wf;
        wf  <= we;
        we  <= wd + t1;
        wd  <= wc;
        wc  <= wb;
        wb  <= wa;
        wa  <= t1 + t2;
      end
      ST_FINAL: begin
        hv[0] <= INIT_H[0] + wa;
        hv[1] <= INIT_H[1] + wb;
        hv[2] <= INIT_H[2] + wc;
        hv[3] <= INIT_H[3] + wd;
        hv[4] <= INIT_H[4] + we;
        hv[5] <= INIT_H[5] + wf;
        hv[6] <= INIT_H[6] + wg;
        hv[7] <= INIT_H[7] + wh;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/sha256_single_block_hash_core.sv =====
// Top level of the single-block SHA-256 hash core
// Message bytes stream in one per transfer and a front end takes one every cycle
// while its command queue has room; bytes past the 55th only flag the message
// as too long. After the end transfer the engine sweeps the byte store to build
// the padded block, runs 64 rounds on one round unit, adds the initial hash and
// then offers the eight digest words H0 first, one per cycle while out_stall is
// low, the last one marked. A too-long message yields one error result instead.
// The engine takes no new message until its result has been taken; the byte-wide
// load sweep and the single round unit set the throughput. The byte store needs
// no clearing pass after reset.
module sha256_single_block_hash_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        too_long,
  output logic        last_word
);
  import sha256sb_pkg::*;

  cmd_t push_cmd;
  cmd_t head_cmd;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;

  sha256sb_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .has_byte       (has_byte),
    .end_of_message (end_of_message),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (push_cmd)
  );

  sha256sb_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .empty    (q_empty)
  );

  sha256sb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_cmd       (head_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest_word (digest_word),
    .word_index  (word_index),
    .too_long    (too_long),
    .last_word   (last_word)
  );

`include "sha256_single_block_hash_core_assert.svh"

  // Error result stands alone and carries no digest
  `SBH_ASSERT_IMP(a_err_single, out_valid && too_long,
    last_word && word_index == 3'd0 && digest_word == 32'd0, "bad error result")

  // Digest words come out in order with no gap in the index
  `SBH_ASSERT_NXT(a_word_order, out_valid && !out_stall && !last_word,
    out_valid && word_index == $past(word_index) + 3'd1, "digest word order broken")

  // A new message never starts mid-digest
  `SBH_ASSERT_NXT(a_restart, out_valid && !out_stall && last_word,
    !out_valid, "result right after last word")

  // The engine only drains commands that are present
  `SBH_ASSERT_IMP(a_pop_nonempty, q_pop, !q_empty, "pop from empty queue")

endmodule
